[rtl/core/slew_limited_drive_command_shaper_unit_macros.svh]
// Assertion macros used by the checker file of the drive command shaper.
`ifndef SLEW_LIMITED_DRIVE_COMMAND_SHAPER_UNIT_MACROS_SVH
`define SLEW_LIMITED_DRIVE_COMMAND_SHAPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SLDCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SLDCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sldcs_pkg.sv]
// Types, register map and constants of the drive command shaper.
package sldcs_pkg;

  localparam int SPEED_W     = 16;
  localparam int STEER_W     = 16;
  localparam int STEP_W      = 16;
  localparam int EGAIN_W     = 24;
  localparam int ELIM_W      = 17;
  localparam int ERPM_W      = 18;
  localparam int SGAIN_W     = 21;
  localparam int SERVO_W     = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 5;
  localparam int REG_IDX_W   = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_STEP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECEL_STEP   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ERPM_GAIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ERPM_LIMIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_GAIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_OFFSET = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_FLOOR  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_CEIL   = 3'd7;

  // Reset values
  localparam logic [SERVO_W-1:0] SERVO_OFFSET_RST = 16'h8000;
  localparam logic [SERVO_W-1:0] SERVO_FLOOR_RST  = 16'h0000;
  localparam logic [SERVO_W-1:0] SERVO_CEIL_RST   = 16'hFFFF;

  localparam logic signed [ERPM_W-1:0] ERPM_OFFSET_DEFAULT = '0;

  typedef struct packed {
    logic        [STEP_W-1:0]  accel_step;
    logic        [STEP_W-1:0]  decel_step;
    logic signed [EGAIN_W-1:0] erpm_gain;
    logic        [ELIM_W-1:0]  erpm_limit;
    logic signed [SGAIN_W-1:0] servo_gain;
    logic        [SERVO_W-1:0] servo_offset;
    logic        [SERVO_W-1:0] servo_floor;
    logic        [SERVO_W-1:0] servo_ceil;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [STEER_W-1:0] target_steer;
  } in_beat_t;

  typedef struct packed {
    logic signed [ERPM_W-1:0]  erpm_command;
    logic        [SERVO_W-1:0] servo_command;
    logic signed [SPEED_W-1:0] smoothed_speed;
    logic                      erpm_was_clipped;
    logic                      servo_was_clipped;
  } out_beat_t;

endpackage

[rtl/core/slew_limited_drive_command_shaper_unit.sv]
// Drive command shaper: each beat carries a target speed and a steering
// angle; the speed is slew limited against the last smoothed speed, scaled
// to an erpm command and clipped, and the steering is scaled to a servo
// position and clipped. One beat is accepted per cycle; a result is
// offered once its beat has passed the input register, then the result
// register. While out_ready is low the result waits, one more beat may
// still enter the input register, and in_ready then drops until the
// result is taken. The rate is set by the last-speed loop through the
// slew clamp. Registers sit on an APB port at byte address 4*index; the
// user must write them only while the block idles, unchecked by the block.
module slew_limited_drive_command_shaper_unit import sldcs_pkg::*; #(
  parameter logic signed [ERPM_W-1:0] ERPM_OFFSET = ERPM_OFFSET_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data
);

  cfg_t cfg;

  // Configuration registers
  sldcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Command datapath
  sldcs_datapath #(
    .ERPM_OFFSET (ERPM_OFFSET)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/sldcs_regs.sv]
// APB configuration registers of the drive command shaper.
module sldcs_regs import sldcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[APB_ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_step   <= '0;
      cfg.decel_step   <= '0;
      cfg.erpm_gain    <= '0;
      cfg.erpm_limit   <= '0;
      cfg.servo_gain   <= '0;
      cfg.servo_offset <= SERVO_OFFSET_RST;
      cfg.servo_floor  <= SERVO_FLOOR_RST;
      cfg.servo_ceil   <= SERVO_CEIL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ACCEL_STEP:   cfg.accel_step   <= pwdata[STEP_W-1:0];
        REG_DECEL_STEP:   cfg.decel_step   <= pwdata[STEP_W-1:0];
        REG_ERPM_GAIN:    cfg.erpm_gain    <= signed'(pwdata[EGAIN_W-1:0]);
        REG_ERPM_LIMIT:   cfg.erpm_limit   <= pwdata[ELIM_W-1:0];
        REG_SERVO_GAIN:   cfg.servo_gain   <= signed'(pwdata[SGAIN_W-1:0]);
        REG_SERVO_OFFSET: cfg.servo_offset <= pwdata[SERVO_W-1:0];
        REG_SERVO_FLOOR:  cfg.servo_floor  <= pwdata[SERVO_W-1:0];
        REG_SERVO_CEIL:   cfg.servo_ceil   <= pwdata[SERVO_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, raw register bits zero-extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ACCEL_STEP:   prdata = {{(APB_DATA_W-STEP_W){1'b0}}, cfg.accel_step};
      REG_DECEL_STEP:   prdata = {{(APB_DATA_W-STEP_W){1'b0}}, cfg.decel_step};
      REG_ERPM_GAIN:    prdata = {{(APB_DATA_W-EGAIN_W){1'b0}}, cfg.erpm_gain};
      REG_ERPM_LIMIT:   prdata = {{(APB_DATA_W-ELIM_W){1'b0}}, cfg.erpm_limit};
      REG_SERVO_GAIN:   prdata = {{(APB_DATA_W-SGAIN_W){1'b0}}, cfg.servo_gain};
      REG_SERVO_OFFSET: prdata = {{(APB_DATA_W-SERVO_W){1'b0}}, cfg.servo_offset};
      REG_SERVO_FLOOR:  prdata = {{(APB_DATA_W-SERVO_W){1'b0}}, cfg.servo_floor};
      REG_SERVO_CEIL:   prdata = {{(APB_DATA_W-SERVO_W){1'b0}}, cfg.servo_ceil};
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/core/sldcs_datapath.sv]
// Input register, slew limiter, scaling and clipping, result register.
module sldcs_datapath import sldcs_pkg::*; #(
  parameter logic signed [ERPM_W-1:0] ERPM_OFFSET = ERPM_OFFSET_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int WIN_W   = SPEED_W + 2;
  localparam int EPROD_W = EGAIN_W + SPEED_W;
  localparam int SPROD_W = SGAIN_W + STEER_W;
  localparam int ESH     = 16;
  localparam int SSH     = 13;
  localparam int SUM_W   = 26;

  in_beat_t                  s1;
  logic                      s1_valid;
  logic signed [SPEED_W-1:0] last_speed;
  logic                      advance;
  logic                      load;

  logic        [STEP_W-1:0]  up, down;
  logic signed [WIN_W-1:0]   lo, hi, tgt, smooth_w;
  logic signed [SPEED_W-1:0] smooth;

  logic signed [EPROD_W-1:0] eprod, eround;
  logic signed [SUM_W-1:0]   esum, elim;
  logic signed [ERPM_W-1:0]  erpm;
  logic                      eclip;

  logic signed [SPROD_W-1:0] sprod, sround;
  logic signed [SUM_W-1:0]   ssum, smin, smax;
  logic        [SERVO_W-1:0] servo;
  logic                      sclip;

  // Handshake: the result register frees up when empty or taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign load     = s1_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= in_data;
    end
  end

  // Slew window; steps swap roles when the last speed is not positive
  always_comb begin
    if (last_speed > 0) begin
      up   = cfg.accel_step;
      down = cfg.decel_step;
    end else begin
      up   = cfg.decel_step;
      down = cfg.accel_step;
    end
    lo  = WIN_W'(last_speed) - signed'({2'b00, down});
    hi  = WIN_W'(last_speed) + signed'({2'b00, up});
    tgt = WIN_W'(s1.target_speed);
    if (tgt < lo) begin
      smooth_w = lo;
    end else if (tgt > hi) begin
      smooth_w = hi;
    end else begin
      smooth_w = tgt;
    end
    smooth = smooth_w[SPEED_W-1:0];
  end

  // Speed to erpm, round half up, offset, symmetric clip
  always_comb begin
    eprod  = EPROD_W'(cfg.erpm_gain) * EPROD_W'(smooth);
    eround = eprod + (EPROD_W'(1) <<< (ESH - 1));
    esum   = SUM_W'(signed'(eround[EPROD_W-1:ESH])) + SUM_W'(ERPM_OFFSET);
    elim   = signed'({{(SUM_W-ELIM_W){1'b0}}, cfg.erpm_limit});
    eclip  = 1'b0;
    if (esum < -elim) begin
      erpm  = ERPM_W'(-elim);
      eclip = 1'b1;
    end else if (esum > elim) begin
      erpm  = ERPM_W'(elim);
      eclip = 1'b1;
    end else begin
      erpm = esum[ERPM_W-1:0];
    end
  end

  // Steering to servo, round half up, offset, clip to [floor, ceiling]
  always_comb begin
    sprod  = SPROD_W'(cfg.servo_gain) * SPROD_W'(s1.target_steer);
    sround = sprod + (SPROD_W'(1) <<< (SSH - 1));
    ssum   = SUM_W'(signed'(sround[SPROD_W-1:SSH])) +
             signed'({{(SUM_W-SERVO_W){1'b0}}, cfg.servo_offset});
    smin   = signed'({{(SUM_W-SERVO_W){1'b0}}, cfg.servo_floor});
    smax   = signed'({{(SUM_W-SERVO_W){1'b0}}, cfg.servo_ceil});
    sclip  = 1'b0;
    if (ssum < smin) begin
      servo = cfg.servo_floor;
      sclip = 1'b1;
    end else if (ssum > smax) begin
      servo = cfg.servo_ceil;
      sclip = 1'b1;
    end else begin
      servo = ssum[SERVO_W-1:0];
    end
  end

  // Speed state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_speed <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        last_speed <= smooth;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.erpm_command      <= erpm;
      out_data.servo_command     <= servo;
      out_data.smoothed_speed    <= smooth;
      out_data.erpm_was_clipped  <= eclip;
      out_data.servo_was_clipped <= sclip;
    end
  end

endmodule

[rtl/core/sldcs_checker.sv]
// Port-level checks of the drive command shaper, bound to the top level.
`include "slew_limited_drive_command_shaper_unit_macros.svh"

module sldcs_checker import sldcs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // A stalled result beat holds
  `SLDCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Nothing is pending right after reset
  `SLDCS_ASSERT_NOW(a_rst_empty, clk, rst, $past(rst), !out_valid, "result valid after reset")

  // Input side is open right after reset
  `SLDCS_ASSERT_NOW(a_rst_ready, clk, rst, $past(rst), in_ready, "not ready after reset")

  // A beat taken under a stalled result fills the input register: ready follows out_ready
  `SLDCS_ASSERT_NEXT(a_fill_stall, clk, rst, out_valid && !out_ready && in_valid && in_ready, out_valid && (in_ready == out_ready), "input register not tracking stall")

endmodule

bind slew_limited_drive_command_shaper_unit sldcs_checker u_checker (.*);

[bench/slew_limited_drive_command_shaper_unit_tb.sv]
// Self-checking testbench of the drive command shaper: predicts every command beat and checks it.
module slew_limited_drive_command_shaper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sldcs_pkg::*;

  localparam int NUM_REGS    = 8;
  localparam int RST_CYCLES  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 4;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_BEATS = 72;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;

  // Predictor state: register copy, last smoothed speed, commands in flight
  cfg_t                      cmd_cfg;
  logic signed [SPEED_W-1:0] speed_hist;
  out_beat_t                 pending_cmds[$];

  int err_count     = 0;
  int beats_checked = 0;
  int tx_count      = 0;
  int cycle_count   = 0;

  // Sender pacing and receiver stall controls
  int         tx_burst_left = 0;
  int         tx_gap_max    = 0;
  bit         rx_free       = 1'b1;
  bit         hold_active   = 1'b0;
  logic [3:0] rx_phase      = '0;
  logic [15:0] rx_pattern   = 16'hFFFF;
  event       rx_hold_go;

  slew_limited_drive_command_shaper_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Slew clamp, erpm scaling and servo scaling of one command beat
  function automatic out_beat_t shape_command(input in_beat_t b);
    longint up_step, down_step, lo, hi, speed, erpm, servo, lim;
    out_beat_t r;
    // accel and decel trade places once the last speed is zero or negative
    if (speed_hist > 0) begin
      up_step   = longint'(cmd_cfg.accel_step);
      down_step = longint'(cmd_cfg.decel_step);
    end else begin
      up_step   = longint'(cmd_cfg.decel_step);
      down_step = longint'(cmd_cfg.accel_step);
    end
    lo = longint'(speed_hist) - down_step;
    hi = longint'(speed_hist) + up_step;
    speed = longint'(b.target_speed);
    if (speed < lo) speed = lo;
    else if (speed > hi) speed = hi;
    speed_hist = speed[SPEED_W-1:0];
    r = '0;
    // round half up: add half an lsb, then floor
    erpm = ((longint'(cmd_cfg.erpm_gain) * speed + 32768) >>> 16)
           + longint'(ERPM_OFFSET_DEFAULT);
    lim = longint'(cmd_cfg.erpm_limit);
    if (erpm < -lim) begin
      erpm = -lim;
      r.erpm_was_clipped = 1'b1;
    end else if (erpm > lim) begin
      erpm = lim;
      r.erpm_was_clipped = 1'b1;
    end
    servo = ((longint'(cmd_cfg.servo_gain) * longint'(b.target_steer) + 4096) >>> 13)
            + longint'(cmd_cfg.servo_offset);
    // lower bound first, so inverted bounds favor the floor
    if (servo < longint'(cmd_cfg.servo_floor)) begin
      servo = longint'(cmd_cfg.servo_floor);
      r.servo_was_clipped = 1'b1;
    end else if (servo > longint'(cmd_cfg.servo_ceil)) begin
      servo = longint'(cmd_cfg.servo_ceil);
      r.servo_was_clipped = 1'b1;
    end
    r.erpm_command   = erpm[ERPM_W-1:0];
    r.servo_command  = servo[SERVO_W-1:0];
    r.smoothed_speed = speed[SPEED_W-1:0];
    return r;
  endfunction

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no beat outstanding", beats_checked));
    end else begin
      want = pending_cmds.pop_front();
      if (got.erpm_command !== want.erpm_command)
        report_mismatch($sformatf("beat %0d erpm_command got %0d exp %0d",
                                  beats_checked, got.erpm_command, want.erpm_command));
      if (got.servo_command !== want.servo_command)
        report_mismatch($sformatf("beat %0d servo_command got %0d exp %0d",
                                  beats_checked, got.servo_command, want.servo_command));
      if (got.smoothed_speed !== want.smoothed_speed)
        report_mismatch($sformatf("beat %0d smoothed_speed got %0d exp %0d",
                                  beats_checked, got.smoothed_speed, want.smoothed_speed));
      if (got.erpm_was_clipped !== want.erpm_was_clipped)
        report_mismatch($sformatf("beat %0d erpm_was_clipped got %b exp %b",
                                  beats_checked, got.erpm_was_clipped, want.erpm_was_clipped));
      if (got.servo_was_clipped !== want.servo_was_clipped)
        report_mismatch($sformatf("beat %0d servo_was_clipped got %b exp %b",
                                  beats_checked, got.servo_was_clipped, want.servo_was_clipped));
    end
    beats_checked++;
  endtask

  // Beat monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      pending_cmds.insert(pending_cmds.size(), shape_command(in_data));
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  // Receiver: random ready pattern, free-running mode, long hold-off
  always @(posedge clk) begin
    rx_phase <= rx_phase + 4'd1;
    if (rx_phase == 4'hF) rx_pattern <= 16'($urandom | $urandom);
    if (rst || hold_active) out_ready <= 1'b0;
    else if (rx_free) out_ready <= 1'b1;
    else out_ready <= rx_pattern[rx_phase];
  end

  // Hold-off counter
  always begin
    @(rx_hold_go);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // APB write: setup, access, then idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ACCEL_STEP:   cmd_cfg.accel_step   = value[STEP_W-1:0];
      REG_DECEL_STEP:   cmd_cfg.decel_step   = value[STEP_W-1:0];
      REG_ERPM_GAIN:    cmd_cfg.erpm_gain    = value[EGAIN_W-1:0];
      REG_ERPM_LIMIT:   cmd_cfg.erpm_limit   = value[ELIM_W-1:0];
      REG_SERVO_GAIN:   cmd_cfg.servo_gain   = value[SGAIN_W-1:0];
      REG_SERVO_OFFSET: cmd_cfg.servo_offset = value[SERVO_W-1:0];
      REG_SERVO_FLOOR:  cmd_cfg.servo_floor  = value[SERVO_W-1:0];
      REG_SERVO_CEIL:   cmd_cfg.servo_ceil   = value[SERVO_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // APB read of one register, compared over the register's width
  task automatic check_readback(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DATA_W-1:0] got, want;
    int w;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ACCEL_STEP:   begin want = 32'(cmd_cfg.accel_step);   w = STEP_W;  end
      REG_DECEL_STEP:   begin want = 32'(cmd_cfg.decel_step);   w = STEP_W;  end
      REG_ERPM_GAIN:    begin want = 32'(cmd_cfg.erpm_gain);    w = EGAIN_W; end
      REG_ERPM_LIMIT:   begin want = 32'(cmd_cfg.erpm_limit);   w = ELIM_W;  end
      REG_SERVO_GAIN:   begin want = 32'(cmd_cfg.servo_gain);   w = SGAIN_W; end
      REG_SERVO_OFFSET: begin want = 32'(cmd_cfg.servo_offset); w = SERVO_W; end
      REG_SERVO_FLOOR:  begin want = 32'(cmd_cfg.servo_floor);  w = SERVO_W; end
      default:          begin want = 32'(cmd_cfg.servo_ceil);   w = SERVO_W; end
    endcase
    if (((got ^ want) & ((32'd1 << w) - 32'd1)) != '0)
      report_mismatch($sformatf("register %0d read %h exp %h", idx, got, want));
    @(posedge clk);
  endtask

  task automatic set_config(input logic [APB_DATA_W-1:0] accel, decel, egain, elim,
                            input logic [APB_DATA_W-1:0] sgain, soff, smin, smax);
    write_reg(REG_ACCEL_STEP, accel);
    write_reg(REG_DECEL_STEP, decel);
    write_reg(REG_ERPM_GAIN, egain);
    write_reg(REG_ERPM_LIMIT, elim);
    write_reg(REG_SERVO_GAIN, sgain);
    write_reg(REG_SERVO_OFFSET, soff);
    write_reg(REG_SERVO_FLOOR, smin);
    write_reg(REG_SERVO_CEIL, smax);
  endtask

  // mode 0: highest, 1: lowest, otherwise a random mix of extremes, small and raw values
  function automatic logic [APB_DATA_W-1:0] pick_reg_value(input logic [REG_IDX_W-1:0] idx,
                                                          input int mode);
    logic [APB_DATA_W-1:0] lo_v, hi_v, r;
    int sel;
    r = $urandom;
    case (idx)
      REG_ERPM_GAIN:  begin lo_v = 32'h0080_0000; hi_v = 32'h007F_FFFF; end
      REG_ERPM_LIMIT: begin lo_v = 32'h0000_0000; hi_v = 32'h0001_FFFF; end
      REG_SERVO_GAIN: begin lo_v = 32'h0010_0000; hi_v = 32'h000F_FFFF; end
      default:        begin lo_v = 32'h0000_0000; hi_v = 32'h0000_FFFF; end
    endcase
    sel = (mode < 2) ? mode : $urandom_range(0, 5);
    case (sel)
      0:       return hi_v;
      1:       return lo_v;
      2, 3:    return r & 32'h0000_03FF;
      default: return r;
    endcase
  endfunction

  // Sender: bursts of beats separated by random gaps, or back to back when tx_gap_max is zero
  task automatic offer_beat(input in_beat_t b);
    int gap;
    if (tx_gap_max > 0 && tx_burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, tx_gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      tx_burst_left = $urandom_range(1, 12);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    tx_count++;
  endtask

  task automatic send_cmd(input logic signed [SPEED_W-1:0] spd,
                          input logic signed [STEER_W-1:0] steer);
    in_beat_t b;
    b.target_speed = spd;
    b.target_steer = steer;
    offer_beat(b);
  endtask

  // Sender pauses until every outstanding result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (beats_checked < tx_count) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Targets often near the last speed so the slew window matters
  function automatic in_beat_t random_command();
    in_beat_t b;
    int t;
    case ($urandom_range(0, 9))
      0:       b.target_speed = 16'sh7FFF;
      1:       b.target_speed = 16'sh8000;
      2, 3:    b.target_speed = SPEED_W'($urandom);
      4:       b.target_speed = -speed_hist;
      default: begin
        t = int'(speed_hist) + int'($urandom_range(0, 2048)) - 1024;
        if (t > 32767) t = 32767;
        else if (t < -32768) t = -32768;
        b.target_speed = t[SPEED_W-1:0];
      end
    endcase
    case ($urandom_range(0, 7))
      0:       b.target_steer = 16'sh7FFF;
      1:       b.target_steer = 16'sh8000;
      2:       b.target_steer = '0;
      default: b.target_steer = STEER_W'($urandom);
    endcase
    return b;
  endfunction

  // Every register at both ends, read back
  task automatic test_register_map();
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(REG_IDX_W'(i), pick_reg_value(REG_IDX_W'(i), 0));
      check_readback(REG_IDX_W'(i));
      write_reg(REG_IDX_W'(i), pick_reg_value(REG_IDX_W'(i), 1));
      check_readback(REG_IDX_W'(i));
    end
  endtask

  // Slew direction swap, erpm and servo clipping, zero limit, inverted bounds, ties
  task automatic test_directed();
    tx_gap_max = 2;
    rx_free    = 1'b0;
    // register defaults after reset
    set_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000, 32'h0, 32'hFFFF);
    send_cmd(16'sd1000, 16'sd1000);
    wait_drain();
    // unequal steps, erpm clip both ways, servo clip both ways
    set_config(32'h0100, 32'h0200, 32'd4096000, 32'd20000,
               32'h4000, 32'd32768, 32'd10000, 32'd55000);
    send_cmd(16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh7FFF, 16'sd0);
    send_cmd(16'sh8000, 16'sd100);
    send_cmd(16'sh8000, -16'sd100);
    send_cmd(16'sh8000, 16'sh8000);
    send_cmd(16'sd0, 16'sh7FFF);
    send_cmd(16'sd100, 16'sd0);
    send_cmd(16'sd0, 16'sh8000);
    send_cmd(16'sd0, 16'sh7FFF);
    wait_drain();
    // zero erpm limit, most negative gain, inverted servo bounds
    set_config(32'hFFFF, 32'hFFFF, 32'h0080_0000, 32'h0,
               32'h000F_FFFF, 32'd30000, 32'd50000, 32'd20000);
    send_cmd(16'sh7FFF, 16'sd0);
    send_cmd(16'sd0, 16'sd100);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000);
    wait_drain();
    // rounding ties on both products
    set_config(32'hFFFF, 32'hFFFF, 32'd2, 32'h0001_FFFF,
               32'd1, 32'd100, 32'd0, 32'hFFFF);
    send_cmd(16'sd16384, 16'sd4096);
    send_cmd(-16'sd16384, -16'sd4096);
    send_cmd(-16'sd16384, -16'sd12288);
    send_cmd(16'sh7FFF, 16'sh8000);
    wait_drain();
  endtask

  // Random beats over several register settings, extremes first
  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      wait_drain();
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(REG_IDX_W'(i), pick_reg_value(REG_IDX_W'(i), p));
      tx_gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
      rx_free    = (p == 2 || p == 5);
      repeat (PHASE_BEATS) offer_beat(random_command());
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_hold_off();
    wait_drain();
    tx_gap_max = 0;
    rx_free    = 1'b0;
    -> rx_hold_go;
    repeat (30) offer_beat(random_command());
  endtask

  // Short bursts, each followed by a full drain
  task automatic test_drain_pause();
    tx_gap_max = 4;
    repeat (4) begin
      repeat (8) offer_beat(random_command());
      wait_drain();
    end
  endtask

  initial begin
    cmd_cfg              = '0;
    cmd_cfg.servo_offset = SERVO_OFFSET_RST;
    cmd_cfg.servo_floor  = SERVO_FLOOR_RST;
    cmd_cfg.servo_ceil   = SERVO_CEIL_RST;
    speed_hist           = '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_map();
    test_directed();
    test_random_phases();
    test_hold_off();
    test_drain_pause();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sldcs_pkg.sv
rtl/core/sldcs_regs.sv
rtl/core/sldcs_datapath.sv
rtl/core/slew_limited_drive_command_shaper_unit.sv
rtl/core/sldcs_checker.sv
bench/slew_limited_drive_command_shaper_unit_tb.sv
